// ----- hdl/evpr_pkg.sv -----
// Shared types and constants for the encoder velocity, position and rpm block.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package evpr_pkg;

  localparam int CNT_W   = 16;  // encoder counter and counter period
  localparam int POS_W   = 32;  // accumulated position
  localparam int VEL_W   = 16;  // saturated velocity
  localparam int RPM_W   = 16;  // saturated speed
  localparam int SPS_W   = 8;   // samples per second
  localparam int DIFF_W  = 19;  // raw wrap difference before saturation
  localparam int K_W     = 12;  // 15 * samples_per_second
  localparam int PROD_W  = 28;  // |velocity| * 15 * samples_per_second
  localparam int RPM_FACTOR = 15;

  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_COUNTER_PERIOD     = 2'd0;
  localparam cfg_idx_t CFG_SAMPLES_PER_SECOND = 2'd1;
  localparam cfg_idx_t CFG_PULSES_PER_REV     = 2'd2;

  // One measured sample handed from the front end to the rpm back end.
  typedef struct packed {
    logic        [CNT_W-1:0] raw_count;
    logic signed [POS_W-1:0] position;
    logic signed [VEL_W-1:0] velocity;
  } sample_t;

endpackage : evpr_pkg

`default_nettype wire

// ----- hdl/evpr_front.sv -----
// Front end: accepts encoder samples, keeps per-motor state and forms velocity and position.
// Depends on evpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module evpr_front #(
  parameter int NUM_MOTORS = 2
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_motor_select,
  input  wire logic [evpr_pkg::CNT_W-1:0]  in_counter_value,
  input  wire logic                        in_counting_down,
  input  wire logic [evpr_pkg::CNT_W-1:0]  counter_period,
  input  wire logic                        q_full,
  output logic                             q_push,
  output evpr_pkg::sample_t                q_push_data
);

  logic                        hold_vld_r, hold_vld_nxt;
  logic                        hold_sel_r;
  logic [evpr_pkg::CNT_W-1:0]  hold_cnt_r;
  logic                        hold_down_r;

  logic [evpr_pkg::CNT_W-1:0]        last_count_r [NUM_MOTORS];
  logic signed [evpr_pkg::POS_W-1:0] position_r   [NUM_MOTORS];
  logic                              seen_first_r [NUM_MOTORS];

  logic                              accept;
  logic                              in_range;
  logic [evpr_pkg::CNT_W-1:0]        cur_last;
  logic signed [evpr_pkg::POS_W-1:0] cur_pos;
  logic                              cur_seen;
  logic signed [evpr_pkg::DIFF_W-1:0] c_s, l_s, p_s, diff;
  logic signed [evpr_pkg::VEL_W-1:0] vel;
  logic signed [evpr_pkg::POS_W-1:0] new_pos;

  assign in_stall = hold_vld_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = hold_vld_r && !q_full;
  assign in_range = (int'(hold_sel_r) < NUM_MOTORS);

  always_comb begin
    cur_last = '0;
    cur_pos  = '0;
    cur_seen = 1'b0;
    for (int m = 0; m < NUM_MOTORS; m++) begin
      if (int'(hold_sel_r) == m) begin
        cur_last = last_count_r[m];
        cur_pos  = position_r[m];
        cur_seen = seen_first_r[m];
      end
    end
  end

  // Wrap-aware difference; a counter beyond the period is taken as is.
  always_comb begin
    c_s = signed'({3'b000, hold_cnt_r});
    l_s = signed'({3'b000, cur_last});
    p_s = signed'({3'b000, counter_period});
    if (hold_cnt_r == cur_last) begin
      diff = '0;
    end else if (hold_cnt_r > cur_last) begin
      diff = hold_down_r ? (c_s - l_s - p_s) : (c_s - l_s);
    end else begin
      diff = hold_down_r ? (c_s - l_s) : (c_s + p_s - l_s);
    end
    if (!in_range || !cur_seen) begin
      vel = '0;
    end else if (diff > 19'sd32767) begin
      vel = 16'sh7FFF;
    end else if (diff < -19'sd32768) begin
      vel = -16'sh8000;
    end else begin
      vel = diff[evpr_pkg::VEL_W-1:0];
    end
    new_pos = cur_pos + {{(evpr_pkg::POS_W-evpr_pkg::VEL_W){vel[evpr_pkg::VEL_W-1]}}, vel};
  end

  always_comb begin
    q_push_data.raw_count = hold_cnt_r;
    q_push_data.position  = in_range ? new_pos : '0;
    q_push_data.velocity  = vel;
  end

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    if (accept) begin
      hold_vld_nxt = 1'b1;
    end else if (q_push) begin
      hold_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_sel_r  <= in_motor_select;
      hold_cnt_r  <= in_counter_value;
      hold_down_r <= in_counting_down;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        last_count_r[m] <= '0;
        position_r[m]   <= '0;
        seen_first_r[m] <= 1'b0;
      end
    end else begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        if (q_push && in_range && int'(hold_sel_r) == m) begin
          last_count_r[m] <= hold_cnt_r;
          position_r[m]   <= new_pos;
          seen_first_r[m] <= 1'b1;
        end
      end
    end
  end

endmodule : evpr_front

`default_nettype wire

// ----- hdl/evpr_queue.sv -----
// Short queue of measured samples between the front end and the rpm back end.
// Depends on evpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module evpr_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire evpr_pkg::sample_t push_data,
  input  wire logic              pop,
  output evpr_pkg::sample_t      pop_data,
  output logic                   full,
  output logic                   empty
);

  localparam int PTR_W = $clog2(evpr_pkg::QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  evpr_pkg::sample_t  entry_r [evpr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full     = (count_r == CNT_W'(evpr_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(evpr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(evpr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : evpr_queue

`default_nettype wire

// ----- hdl/evpr_back.sv -----
// Back end: scales velocity to rpm with a serial divider and holds the result register.
// Depends on evpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module evpr_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [evpr_pkg::SPS_W-1:0]  samples_per_second,
  input  wire logic [evpr_pkg::CNT_W-1:0]  pulses_per_rev,
  input  wire logic                        q_empty,
  input  wire evpr_pkg::sample_t           q_pop_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [evpr_pkg::CNT_W-1:0]       out_raw_count,
  output logic signed [evpr_pkg::POS_W-1:0] out_position,
  output logic signed [evpr_pkg::VEL_W-1:0] out_velocity_counts,
  output logic signed [evpr_pkg::RPM_W-1:0] out_speed_rpm
);

  localparam int STEP_W = $clog2(evpr_pkg::PROD_W);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_FIX  = 5'b01000,
    ST_OUT  = 5'b10000
  } back_state_t;

  back_state_t state_r, state_nxt;
  logic [STEP_W-1:0]                  step_r, step_nxt;
  logic [evpr_pkg::CNT_W-1:0]         raw_r;
  logic signed [evpr_pkg::POS_W-1:0]  pos_r;
  logic signed [evpr_pkg::VEL_W-1:0]  vel_r;
  logic signed [evpr_pkg::RPM_W-1:0]  rpm_r, rpm_nxt;
  logic                               neg_r;
  logic [evpr_pkg::VEL_W-1:0]         mag_r;
  logic [evpr_pkg::PROD_W-1:0]        quo_r, quo_nxt;
  logic [evpr_pkg::CNT_W-1:0]         rem_r, rem_nxt;
  logic [evpr_pkg::K_W-1:0]           k;
  logic [evpr_pkg::CNT_W:0]           shifted;
  logic [evpr_pkg::CNT_W+1:0]         trial;

  assign k = evpr_pkg::K_W'(samples_per_second) * evpr_pkg::K_W'(evpr_pkg::RPM_FACTOR);
  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  assign out_valid           = (state_r == ST_OUT);
  assign out_raw_count       = raw_r;
  assign out_position        = pos_r;
  assign out_velocity_counts = vel_r;
  assign out_speed_rpm       = rpm_r;

  // One restoring division step: the dividend shifts in from the top of quo_r.
  always_comb begin
    shifted = {rem_r, quo_r[evpr_pkg::PROD_W-1]};
    trial   = {1'b0, shifted} - {2'b00, pulses_per_rev};
    if (!trial[evpr_pkg::CNT_W+1]) begin
      rem_nxt = trial[evpr_pkg::CNT_W-1:0];
      quo_nxt = {quo_r[evpr_pkg::PROD_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[evpr_pkg::CNT_W-1:0];
      quo_nxt = {quo_r[evpr_pkg::PROD_W-2:0], 1'b0};
    end
  end

  // The magnitude quotient is truncated, so negating it truncates toward zero.
  always_comb begin
    if (pulses_per_rev == '0) begin
      rpm_nxt = '0;
    end else if (neg_r) begin
      rpm_nxt = (quo_r > evpr_pkg::PROD_W'(32768)) ? -16'sh8000 :
                -signed'(quo_r[evpr_pkg::RPM_W-1:0]);
    end else begin
      rpm_nxt = (quo_r > evpr_pkg::PROD_W'(32767)) ? 16'sh7FFF :
                signed'(quo_r[evpr_pkg::RPM_W-1:0]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
        step_nxt  = '0;
      end
      ST_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(evpr_pkg::PROD_W - 1)) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      raw_r <= q_pop_data.raw_count;
      pos_r <= q_pop_data.position;
      vel_r <= q_pop_data.velocity;
      neg_r <= q_pop_data.velocity[evpr_pkg::VEL_W-1];
      mag_r <= q_pop_data.velocity[evpr_pkg::VEL_W-1] ?
               evpr_pkg::VEL_W'(-q_pop_data.velocity) : q_pop_data.velocity;
    end
    if (state_r == ST_MUL) begin
      quo_r <= evpr_pkg::PROD_W'(mag_r) * evpr_pkg::PROD_W'(k);
      rem_r <= '0;
    end else if (state_r == ST_DIV) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (state_r == ST_FIX) begin
      rpm_r <= rpm_nxt;
    end
  end

endmodule : evpr_back

`default_nettype wire

// ----- hdl/encoder_velocity_position_rpm.sv -----
// Top level of the encoder velocity, position and rpm block: configuration registers,
// front end, sample queue and rpm back end. Depends on evpr_pkg, evpr_front,
// evpr_queue and evpr_back.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   motor_select, counter_value, counting_down
//   out_     output     out_valid / out_stall raw_count, position, velocity_counts, speed_rpm
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// The front end holds each sample in a register until it is queued, and updates the motor's state then.
// The back end then works on one sample at a time: pop, multiply, 28 serial divide steps,
// saturation and output, and pops the next only once idle; this divider sets the sustained rate.
// Reset is synchronous and clears all motor state; the registers return to their defaults.
// A stall on the output holds the result; three more samples enter meanwhile, two in the
// queue and one in the front end's holding register, and then the input stalls.
`timescale 1ns / 1ps
`default_nettype none

module encoder_velocity_position_rpm #(
  parameter int NUM_MOTORS = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_motor_select,
  input  wire logic [evpr_pkg::CNT_W-1:0]    in_counter_value,
  input  wire logic                          in_counting_down,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [evpr_pkg::CNT_W-1:0]         out_raw_count,
  output logic signed [evpr_pkg::POS_W-1:0]  out_position,
  output logic signed [evpr_pkg::VEL_W-1:0]  out_velocity_counts,
  output logic signed [evpr_pkg::RPM_W-1:0]  out_speed_rpm,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire evpr_pkg::cfg_idx_t            cfg_index,
  input  wire logic [evpr_pkg::CNT_W-1:0]    cfg_data
);

  logic [evpr_pkg::CNT_W-1:0] counter_period_r;
  logic [evpr_pkg::SPS_W-1:0] samples_per_second_r;
  logic [evpr_pkg::CNT_W-1:0] pulses_per_rev_r;

  logic              q_push, q_pop, q_full, q_empty;
  evpr_pkg::sample_t q_push_data, q_pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_period_r     <= 16'd65535;
      samples_per_second_r <= 8'd100;
      pulses_per_rev_r     <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        evpr_pkg::CFG_COUNTER_PERIOD:     counter_period_r <= cfg_data;
        evpr_pkg::CFG_SAMPLES_PER_SECOND: samples_per_second_r <= cfg_data[evpr_pkg::SPS_W-1:0];
        evpr_pkg::CFG_PULSES_PER_REV:     pulses_per_rev_r <= cfg_data;
        default: ;
      endcase
    end
  end

  evpr_front #(
    .NUM_MOTORS(NUM_MOTORS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_motor_select  (in_motor_select),
    .in_counter_value (in_counter_value),
    .in_counting_down (in_counting_down),
    .counter_period   (counter_period_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_push_data      (q_push_data)
  );

  evpr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  evpr_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .samples_per_second  (samples_per_second_r),
    .pulses_per_rev      (pulses_per_rev_r),
    .q_empty             (q_empty),
    .q_pop_data          (q_pop_data),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_raw_count       (out_raw_count),
    .out_position        (out_position),
    .out_velocity_counts (out_velocity_counts),
    .out_speed_rpm       (out_speed_rpm)
  );

endmodule : encoder_velocity_position_rpm

`default_nettype wire

// ----- hdl/evpr_checker.sv -----
// Port-level checks for encoder_velocity_position_rpm, attached by the bind at the end.
// Depends on evpr_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module evpr_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [evpr_pkg::CNT_W-1:0]    out_raw_count,
  input wire logic signed [evpr_pkg::POS_W-1:0] out_position,
  input wire logic signed [evpr_pkg::VEL_W-1:0] out_velocity_counts,
  input wire logic signed [evpr_pkg::RPM_W-1:0] out_speed_rpm
);

  // A result transaction never appears in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_raw_count) &&
    $stable(out_position) && $stable(out_velocity_counts) && $stable(out_speed_rpm))
    else $error("stalled result changed");

  a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_velocity_counts == '0 |-> out_speed_rpm == '0)
    else $error("nonzero rpm at zero velocity");

  // Speed keeps the sign of velocity; truncation may only bring it to zero.
  a_sign_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_velocity_counts[evpr_pkg::VEL_W-1] |->
    !out_speed_rpm[evpr_pkg::RPM_W-1])
    else $error("negative rpm for forward velocity");

  a_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_velocity_counts[evpr_pkg::VEL_W-1] |->
    (out_speed_rpm[evpr_pkg::RPM_W-1] || out_speed_rpm == '0))
    else $error("positive rpm for reverse velocity");

endmodule : evpr_checker

bind encoder_velocity_position_rpm evpr_checker u_evpr_checker (.*);

`default_nettype wire
